### rtl/core/fgd_pkg.sv
// Package for the finger gesture detector: beat payload types, the job record
// handed from the lanes to the merging stage, register indexes and gesture codes.
// No dependencies.
package fgd_pkg;

    // Number of fingers, thumb first.
    localparam int NUM_FINGERS = 5;

    // Configuration register indexes.
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_TIMEOUT   = 1'b1;

    // Gesture code for an input without any finger change.
    localparam logic [3:0] CODE_NONE = 4'd0;

    // One input beat: a rotation sample per finger.
    typedef struct packed {
        logic signed [15:0] thumb_rate;
        logic signed [15:0] index_rate;
        logic signed [15:0] middle_rate;
        logic signed [15:0] ring_rate;
        logic signed [15:0] little_rate;
    } sample_t;

    // One result beat.
    typedef struct packed {
        logic [3:0] gesture_code;
        logic [3:0] list_slot;
        logic [4:0] closed_flags;
        logic [4:0] start_flags;
        logic       list_restarted;
        logic       last;
    } gesture_t;

    // Everything the merging stage needs to emit the results of one input.
    typedef struct packed {
        logic [4:0] change;      // finger changed on this input
        logic [4:0] opening;     // the change was an open, else a close
        logic [4:0] old_flags;   // closed flags before this input
        logic [4:0] new_flags;   // closed flags after this input
        logic [4:0] start_flags; // list start flags after this input
        logic       restarted;   // the timeout restarted the list
    } fgd_job_t;

    // Gesture code of a finger: 2f+1 on close, 2f+2 on open.
    function automatic logic [3:0] finger_code(input logic [2:0] finger,
                                               input logic opening);
        return {finger, 1'b0} + (opening ? 4'd2 : 4'd1);
    endfunction

endpackage

### rtl/core/fgd_lane.sv
// One finger lane of the gesture detector: threshold compare against the
// finger's current closed flag. Depends on fgd_pkg.
module fgd_lane
    import fgd_pkg::*;
(
    input  logic signed [15:0] sample,
    input  logic [14:0]        threshold,
    input  logic               closed,
    output logic               change,
    output logic               opening,
    output logic               closed_next
);

    logic signed [16:0] sample_ext;
    logic signed [16:0] thr_pos;
    logic signed [16:0] thr_neg;
    logic               close_hit;
    logic               open_hit;

    // Compare in 17 bits so that the negated threshold always fits.
    always_comb
    begin
        sample_ext  = {sample[15], sample};
        thr_pos     = {2'b00, threshold};
        thr_neg     = -thr_pos;
        close_hit   = (sample_ext > thr_pos) && !closed;
        open_hit    = (sample_ext < thr_neg) && closed;
        change      = close_hit || open_hit;
        opening     = open_hit;
        closed_next = closed ^ change;
    end

endmodule

### rtl/core/fgd_merge.sv
// Merging stage of the gesture detector: walks the changed lanes of one job,
// thumb first, keeps the list write slot and drives the result register.
// Depends on fgd_pkg.
module fgd_merge
    import fgd_pkg::*;
#(
    parameter int MAX_GESTURES = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load_valid,
    input  fgd_job_t load_job,
    output logic     load_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output gesture_t out_data
);

    localparam int SLOT_W = $clog2(MAX_GESTURES);

    logic              job_valid_reg;
    logic              job_valid_next;
    fgd_job_t          job_reg;
    fgd_job_t          job_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    gesture_t          out_reg;
    gesture_t          out_next;

    logic              emit_en;
    logic              emit_last;
    logic              emit_none;
    logic [4:0]        low_fill;
    logic [4:0]        lowest;
    logic [4:0]        rest;
    logic [2:0]        finger;
    logic              finger_opening;
    logic [SLOT_W-1:0] slot_inc;

    // A result leaves the job when the output register is free or drains.
    always_comb
    begin
        emit_en    = job_valid_reg && (!out_valid_reg || out_ready);
        emit_none  = (job_reg.change == 5'd0);
        low_fill   = job_reg.change ^ (job_reg.change - 5'd1);
        lowest     = job_reg.change & ~(job_reg.change - 5'd1);
        rest       = job_reg.change & (job_reg.change - 5'd1);
        emit_last  = (rest == 5'd0);
        load_ready = !job_valid_reg || (emit_en && emit_last);
    end

    // Encode the lowest changed finger.
    always_comb
    begin
        finger         = 3'd0;
        finger_opening = 1'b0;
        for (int f = 0; f < NUM_FINGERS; f++)
        begin
            if (lowest[f])
            begin
                finger         = 3'(f);
                finger_opening = job_reg.opening[f];
            end
        end
    end

    // Write slot advance with wrap at the list length.
    always_comb
    begin
        if (slot_reg == SLOT_W'(MAX_GESTURES - 1))
        begin
            slot_inc = '0;
        end
        else
        begin
            slot_inc = slot_reg + 1'b1;
        end
    end

    // Next result, slot and job.
    always_comb
    begin
        job_valid_next = job_valid_reg;
        job_next       = job_reg;
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (emit_en)
        begin
            out_valid_next          = 1'b1;
            out_next.closed_flags   = (job_reg.new_flags & low_fill)
                                    | (job_reg.old_flags & ~low_fill);
            out_next.start_flags    = job_reg.start_flags;
            out_next.last           = emit_last;
            if (emit_none)
            begin
                out_next.gesture_code   = CODE_NONE;
                out_next.list_slot      = 4'd0;
                out_next.list_restarted = job_reg.restarted;
                if (job_reg.restarted)
                begin
                    slot_next = '0;
                end
            end
            else
            begin
                out_next.gesture_code   = finger_code(finger, finger_opening);
                out_next.list_slot      = 4'(slot_reg);
                out_next.list_restarted = 1'b0;
                slot_next               = slot_inc;
            end
            job_next.change = rest;
            if (emit_last)
            begin
                job_valid_next = 1'b0;
            end
        end

        if (load_valid && load_ready)
        begin
            job_valid_next = 1'b1;
            job_next       = load_job;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            slot_reg      <= '0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            out_valid_reg <= out_valid_next;
            slot_reg      <= slot_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The write slot never points past the end of the list.
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(slot_reg) < MAX_GESTURES)
        else $error("write slot out of range");

    // A job with results still to go stays loaded.
    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_en && !emit_last) |=> job_valid_reg)
        else $error("job dropped before its last result");

    // A list restart only appears on a result without a gesture.
    a_restart_none: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.list_restarted) |-> (out_reg.gesture_code == CODE_NONE))
        else $error("list restart on a gesture result");

endmodule

### rtl/core/finger_gesture_detector.sv
// Finger gesture detector top level: configuration registers, finger state,
// five compare lanes and the merging stage. Depends on fgd_pkg, fgd_lane and
// fgd_merge.
//
// Usage: each beat on the sample channel carries one signed rotation sample
// per finger. The five lanes compare all fingers in the cycle the beat is
// accepted and update the closed flags at once. The merging stage then emits
// one result beat per changed finger, thumb first, one beat per cycle while
// the receiver is ready, or a single 'none' beat when nothing changed; the
// final beat of an input has last set. An accepted sample passes the job
// register and the result register on its way to the gesture channel. The
// next input is taken as the last beat of the previous one leaves the job
// register, so gesture-free inputs are taken one per cycle while the receiver
// keeps up. When the receiver stalls, the result register holds its beat, one
// further input waits in the job register and sample_ready drops until room
// frees up. Reset clears the closed and start flags, the write slot, the idle
// count and both registers; the gesture list entries are not read back by the
// block, so only the write slot is kept. The user must write the registers
// over the APB port only while the block is idle; the block does not enforce it.
module finger_gesture_detector
    import fgd_pkg::*;
#(
    parameter int MAX_GESTURES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  sample_t     sample,
    output logic        gesture_valid,
    input  logic        gesture_ready,
    output gesture_t    gesture,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [14:0] threshold_reg;
    logic [15:0] timeout_reg;
    logic [4:0]  closed_reg;
    logic [4:0]  closed_next;
    logic [4:0]  start_reg;
    logic [4:0]  start_next;
    logic [16:0] idle_reg;
    logic [16:0] idle_next;

    logic            accept;
    logic            cfg_write;
    logic            restart;
    logic [16:0]     idle_inc;
    logic [16:0]     idle_limit;
    logic [15:0]     lane_sample [NUM_FINGERS];
    logic [4:0]      lane_change;
    logic [4:0]      lane_opening;
    logic [4:0]      lane_closed;
    fgd_job_t        job;

    // APB register port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            REG_THRESHOLD: prdata = {17'd0, threshold_reg};
            REG_TIMEOUT:   prdata = {16'd0, timeout_reg};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            timeout_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_THRESHOLD: threshold_reg <= pwdata[14:0];
                REG_TIMEOUT:   timeout_reg   <= pwdata[15:0];
                default:       threshold_reg <= threshold_reg;
            endcase
        end
    end

    // Finger lanes, thumb in lane 0.
    assign lane_sample[0] = sample.thumb_rate;
    assign lane_sample[1] = sample.index_rate;
    assign lane_sample[2] = sample.middle_rate;
    assign lane_sample[3] = sample.ring_rate;
    assign lane_sample[4] = sample.little_rate;

    for (genvar f = 0; f < NUM_FINGERS; f++)
    begin : g_lane
        fgd_lane u_lane (
            .sample      (lane_sample[f]),
            .threshold   (threshold_reg),
            .closed      (closed_reg[f]),
            .change      (lane_change[f]),
            .opening     (lane_opening[f]),
            .closed_next (lane_closed[f])
        );
    end

    // Idle counting and list restart on gesture-free inputs.
    always_comb
    begin
        accept     = sample_valid && sample_ready;
        idle_inc   = idle_reg + 17'd1;
        idle_limit = {1'b0, timeout_reg} + 17'd1;
        idle_next  = idle_reg;
        start_next = start_reg;
        closed_next = closed_reg;
        restart    = 1'b0;
        if (accept)
        begin
            closed_next = lane_closed;
            if (lane_change != 5'd0)
            begin
                idle_next = '0;
            end
            else
            begin
                idle_next = (idle_inc > idle_limit) ? idle_limit : idle_inc;
                if (idle_next > {1'b0, timeout_reg})
                begin
                    restart    = 1'b1;
                    start_next = closed_reg;
                end
            end
        end
    end

    // Job handed to the merging stage.
    always_comb
    begin
        job.change      = lane_change;
        job.opening     = lane_opening;
        job.old_flags   = closed_reg;
        job.new_flags   = lane_closed;
        job.start_flags = start_next;
        job.restarted   = restart;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_reg <= '0;
            start_reg  <= '0;
            idle_reg   <= '0;
        end
        else
        begin
            closed_reg <= closed_next;
            start_reg  <= start_next;
            idle_reg   <= idle_next;
        end
    end

    fgd_merge #(
        .MAX_GESTURES (MAX_GESTURES)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (sample_valid),
        .load_job   (job),
        .load_ready (sample_ready),
        .out_valid  (gesture_valid),
        .out_ready  (gesture_ready),
        .out_data   (gesture)
    );

    // An input with a gesture clears the idle count.
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (lane_change != 5'd0)) |=> (idle_reg == 17'd0))
        else $error("idle count not cleared by a gesture");

endmodule
